@@ rtl/prime_modular_inverse_assert.svh @@
// assertion macros for the modular inverse block
`ifndef PRIME_MODULAR_INVERSE_ASSERT_SVH
`define PRIME_MODULAR_INVERSE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PMI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pmi_pkg.sv @@
package pmi_pkg;

  // default operand width and modulus after reset
  localparam int          WORD_BITS_DEF = 30;
  localparam logic [31:0] MODULUS_RESET = 32'd998244353;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic shift_up;
    logic sub;
    logic finish;
    logic early_out;
  } pmi_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic bad_range;
    logic r1_zero;
    logic can_shift;
    logic k_zero;
  } pmi_status_t;

endpackage

@@ rtl/pmi_ctrl.sv @@
module pmi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pmi_pkg::pmi_status_t status,
  output pmi_pkg::pmi_cmd_t    cmd,
  output logic                busy
);
  import pmi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_ALIGN = 5'b00100,
    S_SUB   = 5'b01000,
    S_FIX   = 5'b10000
  } pmi_state_t;

  pmi_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.bad_range) begin
          cmd.early_out = 1'b1;
          state_next    = S_IDLE;
        end else begin
          state_next = S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (status.r1_zero) begin
          state_next = S_FIX;
        end else if (status.can_shift) begin
          cmd.shift_up = 1'b1;
        end else begin
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        cmd.sub = 1'b1;
        // last quotient bit: datapath swaps, next euclid step
        if (status.k_zero) begin
          state_next = S_ALIGN;
        end
      end
      S_FIX: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/pmi_datapath.sv @@
module pmi_datapath #(
  parameter int WORD_BITS = pmi_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pmi_pkg::pmi_cmd_t    cmd,
  input  logic [WORD_BITS-1:0] modulus,
  input  logic [WORD_BITS-1:0] value,
  output pmi_pkg::pmi_status_t status,
  output logic                 done,
  output logic [WORD_BITS-1:0] inverse,
  output logic                 out_of_range
);
  import pmi_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int KW = $clog2(W + 1);

  // remainders, shifted divisor, coefficients
  logic        [W-1:0]  mod_q;
  logic        [W-1:0]  r0, r1, d;
  logic signed [W+1:0]  t0, t1, td;
  logic        [KW-1:0] k;

  logic        [W:0]    d_wide;
  logic                 sub_ok;
  logic        [W-1:0]  r0_sub;
  logic signed [W+1:0]  t0_sub;
  logic signed [W+1:0]  t0_fix;

  always_comb begin
    d_wide = {d, 1'b0};
    sub_ok = (d <= r0);
    r0_sub = sub_ok ? (r0 - d) : r0;
    t0_sub = sub_ok ? (t0 - td) : t0;
    t0_fix = t0[W+1] ? (t0 + $signed({2'b00, mod_q})) : t0;
    status.bad_range = (r1 >= mod_q);
    status.r1_zero   = (r1 == '0);
    status.can_shift = (d_wide <= {1'b0, r0});
    status.k_zero    = (k == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_q <= modulus;
      r0    <= modulus;
      r1    <= value;
      d     <= value;
      t0    <= '0;
      t1    <= {{(W+1){1'b0}}, 1'b1};
      td    <= {{(W+1){1'b0}}, 1'b1};
      k     <= '0;
    end else if (cmd.shift_up) begin
      d  <= d_wide[W-1:0];
      td <= td <<< 1;
      k  <= k + KW'(1);
    end else if (cmd.sub) begin
      if (k == '0) begin
        // step done: (r0, r1) <- (r1, r0 mod r1)
        r0 <= r1;
        r1 <= r0_sub;
        d  <= r0_sub;
        t0 <= t1;
        t1 <= t0_sub;
        td <= t0_sub;
      end else begin
        r0 <= r0_sub;
        t0 <= t0_sub;
        d  <= d >> 1;
        td <= td >>> 1;
        k  <= k - KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      inverse      <= (r0 == W'(1)) ? t0_fix[W-1:0] : '0;
      out_of_range <= 1'b0;
    end else if (cmd.early_out) begin
      inverse      <= '0;
      out_of_range <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish | cmd.early_out;
    end
  end

endmodule

@@ rtl/prime_modular_inverse.sv @@
// Modular inverse of value modulo the programmed modulus, by a shift-and-subtract
// extended Euclid that settles one quotient bit per compare/subtract cycle. An item is
// taken when start is high and busy is low. Its result shows on inverse and out_of_range
// for exactly one cycle with done high. The receiver cannot stall it, so it must be
// captured in that cycle. An operand at or above the modulus is caught in the check
// state, which gives out_of_range and a zero inverse. Otherwise each Euclid step first
// shifts the divisor up one quotient bit at a time until it is aligned, then subtracts
// and shifts it back down bit by bit, and the last subtract swaps the remainders. A new
// item is not taken until the last one is done. Zero, or an operand sharing a factor
// with the modulus, gives a zero inverse. The modulus is written over the cfg channel
// while no item is in flight; busy is low once done shows.
module prime_modular_inverse #(
  parameter int          WORD_BITS     = pmi_pkg::WORD_BITS_DEF,
  parameter logic [31:0] MODULUS_INIT  = pmi_pkg::MODULUS_RESET
) (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] value,
  // result, one cycle per item
  output logic                 done,
  output logic [WORD_BITS-1:0] inverse,
  output logic                 out_of_range,
  // modulus write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WORD_BITS-1:0] cfg_data
);
  import pmi_pkg::*;

  `include "prime_modular_inverse_assert.svh"

  logic [WORD_BITS-1:0] modulus;
  pmi_cmd_t             cmd;
  pmi_status_t          status;

  // modulus register, only low WORD_BITS bits kept
  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_INIT[WORD_BITS-1:0];
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  // sequencer: check range, align, subtract, swap, final sign fix
  pmi_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // remainder and coefficient registers with the compare/subtract step
  pmi_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .modulus      (modulus),
    .value        (value),
    .status       (status),
    .done         (done),
    .inverse      (inverse),
    .out_of_range (out_of_range)
  );

  // a result only shows once the sequencer is back in idle
  `PMI_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  // rejected operand never carries a nonzero inverse
  `PMI_ASSERT_NOW(a_oor_zero, done && out_of_range, inverse == '0, "nonzero inverse out of range")
  // an accepted item always makes the block busy
  `PMI_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not start")
  // inverse of a good operand stays below the modulus
  `PMI_ASSERT_NOW(a_inv_below, done && !out_of_range, inverse < modulus, "inverse not reduced")

endmodule
